/* rtl/huffman_tree_walk_decoder_assert.svh */
// ----------------------------------------------------------------------------
// huffman tree walk decoder assertion macros
// concurrent assertion helpers shared by the decoder rtl
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_WALK_DECODER_ASSERT_SVH
`define HUFFMAN_TREE_WALK_DECODER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define HTWD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("htwd assertion failed");

// next-cycle implication, checked outside reset
`define HTWD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("htwd assertion failed");

`endif

/* rtl/htwd_pkg.sv */
// ----------------------------------------------------------------------------
// htwd_pkg
// widths, node layout and controller states of the tree walk decoder
// ----------------------------------------------------------------------------
package htwd_pkg;

	localparam int IDX_W          = 9;
	localparam int SYM_W          = 8;
	localparam int BYTE_W         = 8;
	localparam int CNT_W          = 4;
	localparam int NODE_COUNT_DEF = 511;

	localparam logic [CNT_W-1:0] MAX_BITS = CNT_W'(BYTE_W);

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	typedef struct packed {
		logic             leaf;
		logic [SYM_W-1:0] sym;
		logic [IDX_W-1:0] left;
		logic [IDX_W-1:0] right;
	} node_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_NODE,
		ST_CHILD,
		ST_FLUSH
	} state_t;

endpackage

/* rtl/htwd_if.sv */
// ----------------------------------------------------------------------------
// htwd channel interfaces
// valid/ready channels for node writes and code bytes, symbols, root register
// ----------------------------------------------------------------------------
interface htwd_in_if;
	import htwd_pkg::*;

	logic              valid;
	logic              ready;
	logic              operation;
	logic [IDX_W-1:0]  node_index;
	logic              node_is_leaf;
	logic [SYM_W-1:0]  node_symbol;
	logic [IDX_W-1:0]  left_child;
	logic [IDX_W-1:0]  right_child;
	logic [BYTE_W-1:0] code_byte;
	logic [CNT_W-1:0]  valid_bits;

	modport source (
		output valid, operation, node_index, node_is_leaf, node_symbol,
		output left_child, right_child, code_byte, valid_bits,
		input  ready
	);
	modport sink (
		input  valid, operation, node_index, node_is_leaf, node_symbol,
		input  left_child, right_child, code_byte, valid_bits,
		output ready
	);
endinterface

interface htwd_out_if;
	import htwd_pkg::*;

	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol;
	logic             last;

	modport source (output valid, symbol, last, input ready);
	modport sink (input valid, symbol, last, output ready);
endinterface

interface htwd_cfg_if;
	import htwd_pkg::*;

	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

/* rtl/huffman_tree_walk_decoder.sv */
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder
// bit-serial huffman decoder walking a node table held in on-chip memory
// ----------------------------------------------------------------------------
//  channel | dir | transaction
//  cfg     | in  | root node index (9 bits)
//  din     | in  | node write (operation 0) or code byte with bit count (1)
//  dout    | out | decoded symbol, last set on the final symbol of a byte
//
//  a node write is taken in ST_IDLE; a code byte walks each bit through ST_FETCH
//  and ST_NODE, and ST_CHILD as well when the start node is internal, then the
//  byte ends in ST_FLUSH; this order is set by the single read port of the node
//  memory, whose registered read data is needed once or twice per code bit
//  no clearing pass after reset; the node table must be written before it is read, which the block does not enforce
//  a stalled dout holds the walk when a second symbol of the byte is ready
`include "huffman_tree_walk_decoder_assert.svh"

module huffman_tree_walk_decoder #(
	parameter int NODE_COUNT = htwd_pkg::NODE_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	htwd_cfg_if.sink          cfg,
	htwd_in_if.sink           din,
	htwd_out_if.source        dout
);
	import htwd_pkg::*;

	localparam int AddrW = $clog2(NODE_COUNT);

	// node memory, read data registered
	node_t            mem [NODE_COUNT];
	node_t            rd_q;
	logic             zero_q;

	state_t           state_q, state_d;
	logic [IDX_W-1:0] root_q;
	logic [IDX_W-1:0] cur_q;
	logic [IDX_W-1:0] next_q;
	logic             at_root_q;
	logic [BYTE_W-1:0] sh_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pend_valid_q;
	logic [SYM_W-1:0] pend_sym_q;
	logic             out_valid_q;
	logic [SYM_W-1:0] out_sym_q;
	logic             out_last_q;

	node_t            node_eff;
	node_t            wr_node;
	logic             in_fire;
	logic             out_free;
	logic             last_bit;
	logic [CNT_W-1:0] bits_sat;
	logic [31:0]      widx32;
	logic [31:0]      ridx32;

	logic             rd_en;
	logic [IDX_W-1:0] rd_idx;
	logic             emit;
	logic             step;
	logic             take_child;
	logic             push;
	logic             push_last;

	assign in_fire   = din.valid && din.ready;
	assign din.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	assign dout.valid  = out_valid_q;
	assign dout.symbol = out_sym_q;
	assign dout.last   = out_last_q;

	// entries beyond the table read as an internal node with both children 0
	assign node_eff = zero_q ? '0 : rd_q;
	assign out_free = !out_valid_q || dout.ready;
	assign last_bit = (cnt_q == CNT_W'(1));
	assign bits_sat = (din.valid_bits > MAX_BITS) ? MAX_BITS : din.valid_bits;
	assign widx32   = 32'(din.node_index);
	assign ridx32   = 32'(rd_idx);

	assign wr_node.leaf  = din.node_is_leaf;
	assign wr_node.sym   = din.node_symbol;
	assign wr_node.left  = din.left_child;
	assign wr_node.right = din.right_child;

	// datapath controls
	always_comb begin
		rd_en      = 1'b0;
		rd_idx     = at_root_q ? root_q : cur_q;
		emit       = 1'b0;
		step       = 1'b0;
		take_child = 1'b0;
		push       = 1'b0;
		push_last  = 1'b0;
		case (state_q)
			ST_FETCH: begin
				rd_en = 1'b1;
			end
			ST_NODE: begin
				if (node_eff.leaf) begin
					emit = !pend_valid_q || out_free;
					step = emit;
				end else begin
					rd_en  = 1'b1;
					rd_idx = sh_q[BYTE_W-1] ? node_eff.right : node_eff.left;
				end
			end
			ST_CHILD: begin
				if (node_eff.leaf) begin
					emit = !pend_valid_q || out_free;
					step = emit;
				end else begin
					take_child = 1'b1;
					step       = 1'b1;
				end
			end
			ST_FLUSH: begin
				push      = pend_valid_q && out_free;
				push_last = 1'b1;
			end
			default: ;
		endcase
		// a new symbol pushes the held one out as not last
		if (emit && pend_valid_q) begin
			push = 1'b1;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && din.operation == OP_DECODE && bits_sat != '0) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				state_d = ST_NODE;
			end
			ST_NODE: begin
				if (!node_eff.leaf) begin
					state_d = ST_CHILD;
				end else if (step) begin
					state_d = last_bit ? ST_FLUSH : ST_FETCH;
				end
			end
			ST_CHILD: begin
				if (step) begin
					state_d = last_bit ? ST_FLUSH : ST_FETCH;
				end
			end
			ST_FLUSH: begin
				if (!pend_valid_q || out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// node memory
	always_ff @(posedge clk) begin
		if (in_fire && din.operation == OP_WRITE && widx32 < 32'(NODE_COUNT)) begin
			mem[widx32[AddrW-1:0]] <= wr_node;
		end
		if (rd_en) begin
			rd_q   <= mem[ridx32[AddrW-1:0]];
			zero_q <= !(ridx32 < 32'(NODE_COUNT));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			root_q       <= '0;
			cur_q        <= '0;
			at_root_q    <= 1'b1;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				root_q <= cfg.data;
			end
			if (emit) begin
				at_root_q <= 1'b1;
				cur_q     <= root_q;
			end else if (take_child) begin
				at_root_q <= 1'b0;
				cur_q     <= next_q;
			end
			if (state_q == ST_IDLE && in_fire) begin
				cnt_q <= bits_sat;
			end else if (step) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (emit) begin
				pend_valid_q <= 1'b1;
			end else if (push) begin
				pend_valid_q <= 1'b0;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_fire) begin
			sh_q <= din.code_byte;
		end else if (step) begin
			sh_q <= {sh_q[BYTE_W-2:0], 1'b0};
		end
		if (state_q == ST_NODE && !node_eff.leaf) begin
			next_q <= rd_idx;
		end
		if (emit) begin
			pend_sym_q <= node_eff.sym;
		end
		if (push) begin
			out_sym_q  <= pend_sym_q;
			out_last_q <= push_last;
		end
	end

	// no symbol may be held back once the byte is finished
	`HTWD_ASSERT_IMP(a_idle_no_pend, clk, arst_n, state_q == ST_IDLE, !pend_valid_q)
	// bits remain while the walk is running
	`HTWD_ASSERT_IMP(a_walk_has_bits, clk, arst_n,
		state_q == ST_FETCH || state_q == ST_NODE || state_q == ST_CHILD, cnt_q != '0)
	// a child lookup only follows an internal start node
	`HTWD_ASSERT_IMP(a_child_after_node, clk, arst_n, state_q == ST_CHILD,
		$past(state_q) == ST_NODE || $past(state_q) == ST_CHILD)

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the huffman tree walk decoder: a directed table of
// node writes and code bytes, then random trees under several root settings,
// with every symbol compared against an in-bench tree walk or, for typed
// table entries, against the symbol typed into the table
module tb_top;
	import htwd_pkg::*;

	localparam int NODES        = NODE_COUNT_DEF;
	localparam int IDLE_PCT     = 38;
	localparam int SETTLE_CYCLES = 40;

	typedef struct packed {
		logic              op;
		logic [IDX_W-1:0]  idx;
		logic              leaf;
		logic [SYM_W-1:0]  sym;
		logic [IDX_W-1:0]  lc;
		logic [IDX_W-1:0]  rc;
		logic [BYTE_W-1:0] code;
		logic [CNT_W-1:0]  nbits;
		logic              typed;
		logic [SYM_W-1:0]  t_sym;
	} stim_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             last;
	} sym_res_t;

	logic clk = 1'b0;
	logic arst_n;

	htwd_cfg_if cfg_ch ();
	htwd_in_if  din_ch ();
	htwd_out_if dout_ch ();

	huffman_tree_walk_decoder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.din    (din_ch),
		.dout   (dout_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mirror of the decoder state
	node_t            node_mirror [0:NODES-1];
	logic [IDX_W-1:0] walk_pos;
	bit               walk_at_root;
	logic [IDX_W-1:0] root_idx;

	sym_res_t symbol_q [$];
	sym_res_t walk_syms [$];
	stim_t    plan [$];
	bit       used [0:NODES-1];
	int       mismatches;
	bit       steady;

	task automatic report_mismatch(input string msg);
		$display("%0t: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	function automatic node_t fetch_node(input logic [IDX_W-1:0] idx);
		if (idx >= NODES)
			return '0;
		return node_mirror[idx];
	endfunction

	// one step per code bit, leaf symbols collected in walk_syms
	function automatic void walk_code(input logic [BYTE_W-1:0] code,
			input logic [CNT_W-1:0] nbits);
		int               n;
		logic [IDX_W-1:0] start;
		logic [IDX_W-1:0] nxt;
		node_t            cur;
		node_t            child;
		bit               hit;
		logic [SYM_W-1:0] s;
		walk_syms.delete();
		n = (nbits > MAX_BITS) ? BYTE_W : int'(nbits);
		for (int b = 0; b < n; b++) begin
			start = walk_at_root ? root_idx : walk_pos;
			cur = fetch_node(start);
			hit = 1'b0;
			s = '0;
			if (cur.leaf) begin
				// walk sits on a leaf: bit consumed, its symbol emitted
				hit = 1'b1;
				s = cur.sym;
			end else begin
				nxt = code[BYTE_W-1-b] ? cur.right : cur.left;
				child = fetch_node(nxt);
				if (child.leaf) begin
					hit = 1'b1;
					s = child.sym;
				end else begin
					walk_pos = nxt;
					walk_at_root = 1'b0;
				end
			end
			if (hit) begin
				walk_at_root = 1'b1;
				walk_pos = root_idx;
				walk_syms.push_back('{symbol: s, last: 1'b0});
			end
		end
		if (walk_syms.size() > 0)
			walk_syms[walk_syms.size()-1].last = 1'b1;
	endfunction

	function automatic stim_t node_wr(input int idx, input logic leaf, input int sym,
			input int lc, input int rc);
		stim_t s;
		s.op    = OP_WRITE;
		s.idx   = IDX_W'(idx);
		s.leaf  = leaf;
		s.sym   = SYM_W'(sym);
		s.lc    = IDX_W'(lc);
		s.rc    = IDX_W'(rc);
		s.code  = BYTE_W'($urandom_range(0, 255));
		s.nbits = CNT_W'($urandom_range(0, 8));
		s.typed = 1'b0;
		s.t_sym = '0;
		return s;
	endfunction

	function automatic stim_t code_rd(input int code, input int nbits, input logic typed,
			input int t_sym);
		stim_t s;
		s.op    = OP_DECODE;
		s.idx   = IDX_W'($urandom_range(0, NODES-1));
		s.leaf  = 1'($urandom_range(0, 1));
		s.sym   = SYM_W'($urandom_range(0, 255));
		s.lc    = IDX_W'($urandom_range(0, NODES-1));
		s.rc    = IDX_W'($urandom_range(0, NODES-1));
		s.code  = BYTE_W'(code);
		s.nbits = CNT_W'(nbits);
		s.typed = typed;
		s.t_sym = SYM_W'(t_sym);
		return s;
	endfunction

	task automatic send_item(input stim_t it);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			din_ch.valid <= 1'b0;
			@(posedge clk);
		end
		din_ch.valid        <= 1'b1;
		din_ch.operation    <= it.op;
		din_ch.node_index   <= it.idx;
		din_ch.node_is_leaf <= it.leaf;
		din_ch.node_symbol  <= it.sym;
		din_ch.left_child   <= it.lc;
		din_ch.right_child  <= it.rc;
		din_ch.code_byte    <= it.code;
		din_ch.valid_bits   <= it.nbits;
		do
			@(posedge clk);
		while (!din_ch.ready);
		if (it.op == OP_WRITE) begin
			if (it.idx < NODES)
				node_mirror[it.idx] = '{leaf: it.leaf, sym: it.sym, left: it.lc, right: it.rc};
		end else begin
			walk_code(it.code, it.nbits);
			if (it.typed)
				symbol_q.push_back('{symbol: it.t_sym, last: 1'b1});
			else
				foreach (walk_syms[i])
					symbol_q.push_back(walk_syms[i]);
		end
	endtask

	// drops valid, then lets the block drain and settle
	task automatic wait_idle();
		din_ch.valid <= 1'b0;
		while (symbol_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_root(input int r);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= IDX_W'(r);
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		root_idx = IDX_W'(r);
	endtask

	function automatic int fresh_index();
		int idx;
		do
			idx = $urandom_range(0, NODES-1);
		while (used[idx]);
		used[idx] = 1'b1;
		return idx;
	endfunction

	// builds a fresh tree under root r (children always written before parents),
	// then streams code bytes with some node-write noise mixed in
	task automatic run_phase(input int r, input int leaves, input bit skew, input int decodes);
		int pool [$];
		int tree_nodes [$];
		int a;
		int b;
		int p;
		int k;
		int roll;
		wait_idle();
		set_root(r);
		foreach (used[i])
			used[i] = 1'b0;
		used[r] = 1'b1;
		if (leaves == 1) begin
			send_item(node_wr(r, 1'b1, $urandom_range(0, 255), $urandom_range(0, NODES-1),
				$urandom_range(0, NODES-1)));
			tree_nodes.push_back(r);
		end else begin
			for (int i = 0; i < leaves; i++) begin
				p = fresh_index();
				send_item(node_wr(p, 1'b1, $urandom_range(0, 255), $urandom_range(0, NODES-1),
					$urandom_range(0, NODES-1)));
				pool.push_back(p);
				tree_nodes.push_back(p);
			end
			while (pool.size() > 1) begin
				if (skew) begin
					// chain of internal nodes: deep walks across byte boundaries
					a = pool.pop_back();
					b = pool.pop_back();
				end else begin
					k = $urandom_range(0, pool.size()-1);
					a = pool[k];
					pool.delete(k);
					k = $urandom_range(0, pool.size()-1);
					b = pool[k];
					pool.delete(k);
				end
				p = (pool.size() == 0) ? r : fresh_index();
				if ($urandom_range(0, 1))
					send_item(node_wr(p, 1'b0, $urandom_range(0, 255), a, b));
				else
					send_item(node_wr(p, 1'b0, $urandom_range(0, 255), b, a));
				pool.push_back(p);
				tree_nodes.push_back(p);
			end
		end
		for (int i = 0; i < decodes; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 6) begin
				// leaf dropped anywhere, possibly over part of the tree
				send_item(node_wr($urandom_range(0, NODES-1), 1'b1, $urandom_range(0, 255),
					$urandom_range(0, NODES-1), $urandom_range(0, NODES-1)));
			end else if (roll < 10) begin
				a = tree_nodes[$urandom_range(0, tree_nodes.size()-1)];
				b = tree_nodes[$urandom_range(0, tree_nodes.size()-1)];
				send_item(node_wr(fresh_index(), 1'b0, $urandom_range(0, 255), a, b));
			end else if (roll < 72) begin
				send_item(code_rd($urandom_range(0, 255), 8, 1'b0, 0));
			end else begin
				send_item(code_rd($urandom_range(0, 255), $urandom_range(0, 8), 1'b0, 0));
			end
		end
	endtask

	always @(posedge clk) begin : sym_check
		sym_res_t want;
		if (arst_n && dout_ch.valid && dout_ch.ready) begin
			if (symbol_q.size() == 0) begin
				report_mismatch($sformatf("symbol %02h with nothing pending", dout_ch.symbol));
			end else begin
				want = symbol_q.pop_front();
				if (dout_ch.symbol !== want.symbol)
					report_mismatch($sformatf("symbol %02h, want %02h", dout_ch.symbol,
						want.symbol));
				if (dout_ch.last !== want.last)
					report_mismatch($sformatf("last %b, want %b on symbol %02h",
						dout_ch.last, want.last, want.symbol));
			end
		end
		dout_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	initial begin
		arst_n              <= 1'b0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.data         <= '0;
		din_ch.valid        <= 1'b0;
		din_ch.operation    <= OP_WRITE;
		din_ch.node_index   <= '0;
		din_ch.node_is_leaf <= 1'b0;
		din_ch.node_symbol  <= '0;
		din_ch.left_child   <= '0;
		din_ch.right_child  <= '0;
		din_ch.code_byte    <= '0;
		din_ch.valid_bits   <= '0;
		mismatches   = 0;
		steady       = 1'b0;
		walk_pos     = '0;
		walk_at_root = 1'b1;
		root_idx     = '0;
		foreach (node_mirror[i])
			node_mirror[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// root stays at its reset value of 0 for the whole table
		plan = '{
			node_wr(0, 1'b1, 8'hA5, 0, 0),              // one-leaf tree
			code_rd(8'h00, 1, 1'b1, 8'hA5),
			code_rd(8'hFF, 8, 1'b0, 0),                 // one symbol per bit
			code_rd(8'hFF, 0, 1'b0, 0),                 // no bits, no symbol
			node_wr(510, 1'b1, 8'hFF, 510, 510),
			node_wr(509, 1'b1, 8'h00, 0, 0),
			node_wr(1, 1'b1, 8'h5A, 0, 0),
			node_wr(2, 1'b0, 8'h00, 510, 509),
			node_wr(0, 1'b0, 8'h00, 1, 2),              // 0 -> 5a, 10 -> ff, 11 -> 00
			code_rd(8'h00, 1, 1'b1, 8'h5A),
			code_rd(8'h80, 2, 1'b1, 8'hFF),
			code_rd(8'hC0, 1, 1'b0, 0),                 // code left open at node 2
			code_rd(8'h80, 1, 1'b1, 8'h00),
			code_rd(8'h00, 8, 1'b0, 0),
			code_rd(8'hA5, 8, 1'b0, 0),
			code_rd(8'hFF, 7, 1'b0, 0),
			code_rd(8'h80, 1, 1'b0, 0),
			node_wr(3, 1'b1, 8'h3C, 0, 0),              // write while a code is open
			code_rd(8'h00, 1, 1'b1, 8'hFF),
			code_rd(8'h80, 1, 1'b0, 0),
			node_wr(2, 1'b1, 8'h77, 0, 0),              // walk position turns into a leaf
			code_rd(8'h00, 1, 1'b1, 8'h77),
			code_rd(8'h40, 2, 1'b0, 0)
		};
		foreach (plan[i])
			send_item(plan[i]);

		run_phase(510, 6, 1'b0, 45);
		run_phase(0, 1, 1'b0, 12);
		steady = 1'b1;
		run_phase($urandom_range(1, 509), 20, 1'b1, 50);
		steady = 1'b0;
		run_phase($urandom_range(0, 510), 12, 1'b0, 50);
		run_phase($urandom_range(0, 510), 3, 1'b0, 40);
		run_phase($urandom_range(0, 510), 30, 1'b0, 45);

		wait_idle();
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

/* huffman_tree_walk_decoder.f */
+incdir+rtl
rtl/htwd_pkg.sv
rtl/htwd_if.sv
rtl/huffman_tree_walk_decoder.sv
verif/tb_top.sv
